// File: src/slrp_pkg.sv
// Shared types and constants for the slice layer record parser.
// No dependencies; imported by slice_layer_record_parser_core.
package slrp_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned KIND_W         = 3;
  localparam logic [3:0]  HDR_LEN        = 4'd10;

  // Opcodes
  localparam logic [7:0] OP_HEADER   = 8'd1;
  localparam logic [7:0] OP_LAYER_END = 8'd2;
  localparam logic [7:0] OP_POLYLINE = 8'd3;
  localparam logic [7:0] OP_HATCH    = 8'd4;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_OPCODE  = 4'd1,
    PH_HDR     = 4'd2,
    PH_HDR_PAD = 4'd3,
    PH_REC_PAD = 4'd4,
    PH_CNT_HI  = 4'd5,
    PH_CNT_LO  = 4'd6,
    PH_CO_HI   = 4'd7,
    PH_CO_LO   = 4'd8
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    EV_POLY   = 3'd0,
    EV_HATCH  = 3'd1,
    EV_COORD  = 3'd2,
    EV_END    = 3'd3,
    EV_BADOP  = 3'd4,
    EV_BADPAD = 3'd5,
    EV_WARN   = 3'd6
  } event_kind_t;

endpackage

// File: src/slice_layer_record_parser_core.sv
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; input ready drops only while a result waits on out_ready.
// Bytes that cause no result pass without a bubble.
// Reset (rst_n low, synchronous): parser idle awaiting a layer start, counters and
// held bytes cleared, output register empty.
module slice_layer_record_parser_core #(
  parameter int unsigned COORD_BITS = slrp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [slrp_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                         in_layer_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [slrp_pkg::KIND_W-1:0]  out_event_kind,
  output logic [COORD_BITS-1:0]        out_value,
  output logic                         out_last_of_record
);
  import slrp_pkg::*;

  localparam int unsigned HOLD_W = COORD_BITS - BYTE_W;
  localparam int unsigned REM_W  = COORD_BITS + 2;

  phase_t              phase_r, phase_nxt, phase_eff;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt, rem_dec, rem_load;
  logic                hatch_r, hatch_nxt;

  logic                out_valid_r;
  event_kind_t         kind_r, kind_nxt;
  logic [COORD_BITS-1:0] value_r, value_nxt, word;
  logic                last_r, last_nxt;
  logic                emit;

  logic in_fire;
  logic out_fire;

  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid_r & out_ready;

  assign out_valid          = out_valid_r;
  assign out_event_kind     = kind_r;
  assign out_value          = value_r;
  assign out_last_of_record = last_r;

  // A layer start overrides whatever record is in progress.
  assign phase_eff = in_layer_start ? PH_OPCODE : phase_r;
  assign word      = {hold_r, in_data_byte};
  assign cnt_inc   = cnt_r + 4'd1;
  assign rem_load  = hatch_r ? {word, 2'b00} : {1'b0, word, 1'b0};
  assign rem_dec   = (rem_r != '0) ? rem_r - {{(REM_W-1){1'b0}}, 1'b1} : rem_r;

  always_comb begin
    phase_nxt = phase_eff;
    cnt_nxt   = cnt_r;
    hold_nxt  = hold_r;
    rem_nxt   = rem_r;
    hatch_nxt = hatch_r;
    emit      = 1'b0;
    kind_nxt  = EV_END;
    value_nxt = '0;
    last_nxt  = 1'b0;
    case (phase_eff)
      PH_OPCODE: begin
        if (in_data_byte == OP_HEADER) begin
          cnt_nxt   = '0;
          phase_nxt = PH_HDR;
        end else if (in_data_byte == OP_LAYER_END) begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
          kind_nxt  = EV_END;
        end else if (in_data_byte == OP_POLYLINE || in_data_byte == OP_HATCH) begin
          hatch_nxt = (in_data_byte == OP_HATCH);
          phase_nxt = PH_REC_PAD;
        end else begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
          kind_nxt  = EV_BADOP;
        end
      end
      PH_HDR: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= HDR_LEN) phase_nxt = PH_HDR_PAD;
      end
      PH_HDR_PAD: begin
        cnt_nxt   = '0;
        phase_nxt = PH_OPCODE;
        if (in_data_byte != '0) begin
          emit     = 1'b1;
          kind_nxt = EV_WARN;
        end
      end
      PH_REC_PAD: begin
        if (in_data_byte != '0) begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
          kind_nxt  = EV_BADPAD;
        end else begin
          phase_nxt = PH_CNT_HI;
        end
      end
      PH_CNT_HI, PH_CO_HI: begin
        hold_nxt  = in_data_byte[HOLD_W-1:0];
        phase_nxt = (phase_eff == PH_CNT_HI) ? PH_CNT_LO : PH_CO_LO;
      end
      PH_CNT_LO: begin
        rem_nxt   = rem_load;
        phase_nxt = (rem_load != '0) ? PH_CO_HI : PH_OPCODE;
        emit      = 1'b1;
        kind_nxt  = hatch_r ? EV_HATCH : EV_POLY;
        value_nxt = word;
      end
      PH_CO_LO: begin
        rem_nxt   = rem_dec;
        emit      = 1'b1;
        kind_nxt  = EV_COORD;
        value_nxt = word;
        if (rem_dec == '0) begin
          phase_nxt = PH_OPCODE;
          last_nxt  = 1'b1;
        end else begin
          phase_nxt = PH_CO_HI;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      hold_r  <= '0;
      rem_r   <= '0;
      hatch_r <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hold_r  <= hold_nxt;
      rem_r   <= rem_nxt;
      hatch_r <= hatch_nxt;
    end
  end

  // Output register: load on a result beat, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      last_r  <= last_nxt;
    end
  end

`ifndef SYNTHESIS
  a_coord_phase_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CO_HI || phase_r == PH_CO_LO) |-> rem_r != '0)
    else $error("coordinate phase with zero remaining count");

  a_last_only_on_coord: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> kind_r == EV_COORD)
    else $error("last flag on a non-coordinate beat");

  a_hdr_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HDR) |-> cnt_r < HDR_LEN)
    else $error("header byte count out of range");

  a_no_emit_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_fire)
    else $error("byte accepted while result register is blocked");

  a_badop_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit && kind_nxt == EV_BADOP) |=> phase_r == PH_IDLE)
    else $error("parser not idle after bad opcode");
`endif

endmodule
